// ===== hdl/mdd_pkg.sv =====
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared types and constants for the marker-delimited message deframer.
// ----------------------------------------------------------------------------
package mdd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    // Mode codes
    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_LEAD = 2'd1;
    localparam logic [1:0] MODE_BODY = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_PREFIX_CHAR  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SUFFIX_CHAR  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_BODY_LEN = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] PREFIX_CHAR_RST  = 8'd43;
    localparam logic [BYTE_W-1:0] SUFFIX_CHAR_RST  = 8'd126;
    localparam logic [LEN_W-1:0]  MAX_BODY_LEN_RST = 16'd1024;

    typedef struct packed {
        logic push;
        logic clear;
    } mdd_dl_ctrl_t;

endpackage

// ===== hdl/mdd_in_if.sv =====
// ----------------------------------------------------------------------------
// mdd_in_if
// Received-byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface mdd_in_if;
    import mdd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/mdd_out_if.sv =====
// ----------------------------------------------------------------------------
// mdd_out_if
// Result channel: valid/ready handshake carrying body bytes and message events.
// ----------------------------------------------------------------------------
interface mdd_out_if;
    import mdd_pkg::*;

    logic              valid;
    logic              ready;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
    logic              aborted;
    logic [LEN_W-1:0]  msg_length;

    modport source (output valid, output data_valid, output data_byte,
                    output end_of_message, output aborted, output msg_length,
                    input ready);
    modport sink (input valid, input data_valid, input data_byte,
                  input end_of_message, input aborted, input msg_length,
                  output ready);
endinterface

// ===== hdl/mdd_delay_line.sv =====
// ----------------------------------------------------------------------------
// mdd_delay_line
// Tail delay line holding the last DEPTH body bytes, with a fill count.
// ----------------------------------------------------------------------------
module mdd_delay_line #(
    parameter int DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mdd_pkg::mdd_dl_ctrl_t     ctrl,
    input  logic [mdd_pkg::BYTE_W-1:0] din,
    output logic                      full,
    output logic [mdd_pkg::BYTE_W-1:0] head
);
    import mdd_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    logic [BYTE_W-1:0] shift_reg [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign full = (fill_reg == FILL_MAX);
    assign head = shift_reg[0];

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.push && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // oldest byte sits at entry 0
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                shift_reg[i] <= shift_reg[i+1];
            end
            shift_reg[DEPTH-1] <= din;
        end
    end

endmodule

// ===== hdl/marker_delimited_message_deframer_top.sv =====
// ----------------------------------------------------------------------------
// marker_delimited_message_deframer_top
// Finds messages framed by repeated prefix and suffix bytes and streams bodies.
// ----------------------------------------------------------------------------
// Usage:
//   rx_item carries one received byte per item. res carries one result per
//   item that yields a body byte, an end of message or an abort; other items
//   give no result. Body bytes come out MARKER_LEN bytes late, so the end
//   marker itself is never delivered; end_of_message carries the body length.
//   Throughput is one byte per cycle. A result is registered and shows on res
//   the cycle after its byte is accepted. The output register is refilled in
//   the same cycle it is drained, so rx_item stalls only while res holds a
//   result that the receiver does not take.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user keeps
//   writes to idle times, unchecked by the block; other indexes are ignored.
//   Reset sets the registers to their defaults, empties the output register
//   and starts hunting for a prefix run. No clearing pass is needed.
// ----------------------------------------------------------------------------
module marker_delimited_message_deframer_top #(
    parameter int MARKER_LEN = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mdd_in_if.sink                      rx_item,
    mdd_out_if.source                   res,
    input  logic                        cfg_we,
    input  logic [mdd_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mdd_pkg::CFG_W-1:0]   cfg_data
);
    import mdd_pkg::*;

    localparam int RUN_W = $clog2(MARKER_LEN + 1);
    localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(MARKER_LEN);
    localparam logic [LEN_W-1:0] MARK_LEN = LEN_W'(MARKER_LEN);

    logic [BYTE_W-1:0] prefix_char_reg;
    logic [BYTE_W-1:0] suffix_char_reg;
    logic [LEN_W-1:0]  max_body_len_reg;

    logic [1:0]        mode_reg, mode_next;
    logic [RUN_W-1:0]  prefix_run_reg, prefix_run_next;
    logic [RUN_W-1:0]  suffix_run_reg, suffix_run_next;
    logic [LEN_W-1:0]  body_count_reg, body_count_next;

    logic              res_valid_reg, res_valid_next;
    logic              data_valid_reg, data_valid_next;
    logic [BYTE_W-1:0] data_byte_reg, data_byte_next;
    logic              eom_reg, eom_next;
    logic              aborted_reg, aborted_next;
    logic [LEN_W-1:0]  msg_length_reg, msg_length_next;

    mdd_dl_ctrl_t      dl_ctrl;
    logic              dl_full;
    logic [BYTE_W-1:0] dl_head;

    logic              accept;
    logic              is_prefix;
    logic              is_suffix;
    logic              do_hunt;
    logic              do_body;
    logic [RUN_W-1:0]  hunt_run;
    logic [RUN_W-1:0]  hunt_run_inc;
    logic [RUN_W-1:0]  sfx_run_inc;
    logic [LEN_W-1:0]  count_inc;

    assign rx_item.ready = !res_valid_reg || res.ready;
    assign accept        = rx_item.valid && rx_item.ready;

    assign is_prefix = (rx_item.rx_byte == prefix_char_reg);
    assign is_suffix = (rx_item.rx_byte == suffix_char_reg);

    assign do_hunt = (mode_reg == MODE_HUNT) || ((mode_reg == MODE_SKIP) && !is_suffix);
    assign do_body = (mode_reg == MODE_BODY) || ((mode_reg == MODE_LEAD) && !is_prefix);

    // skip mode restarts the prefix run before hunting
    assign hunt_run     = (mode_reg == MODE_SKIP) ? '0 : prefix_run_reg;
    assign hunt_run_inc = (hunt_run == RUN_FULL) ? hunt_run : hunt_run + 1'b1;
    assign sfx_run_inc  = (suffix_run_reg == RUN_FULL) ? suffix_run_reg
                                                       : suffix_run_reg + 1'b1;
    assign count_inc    = body_count_reg + 1'b1;

    always_comb
    begin
        mode_next       = mode_reg;
        prefix_run_next = prefix_run_reg;
        suffix_run_next = suffix_run_reg;
        body_count_next = body_count_reg;
        dl_ctrl         = '0;

        data_valid_next = 1'b0;
        data_byte_next  = '0;
        eom_next        = 1'b0;
        aborted_next    = 1'b0;
        msg_length_next = '0;

        if (accept && do_hunt)
        begin
            mode_next = MODE_HUNT;
            if (is_prefix)
            begin
                prefix_run_next = hunt_run_inc;
                if (hunt_run_inc == RUN_FULL)
                begin
                    mode_next       = MODE_LEAD;
                    prefix_run_next = '0;
                    suffix_run_next = '0;
                    body_count_next = '0;
                    dl_ctrl.clear   = 1'b1;
                end
            end
            else
            begin
                prefix_run_next = '0;
            end
        end
        else if (accept && do_body)
        begin
            mode_next       = MODE_BODY;
            dl_ctrl.push    = 1'b1;
            body_count_next = count_inc;
            suffix_run_next = is_suffix ? sfx_run_inc : '0;
            if (dl_full)
            begin
                data_valid_next = 1'b1;
                data_byte_next  = dl_head;
            end
            if (suffix_run_next == RUN_FULL)
            begin
                eom_next        = 1'b1;
                msg_length_next = count_inc - MARK_LEN;
                mode_next       = MODE_SKIP;
            end
            else if (count_inc >= max_body_len_reg)
            begin
                aborted_next    = 1'b1;
                data_valid_next = 1'b0;
                data_byte_next  = '0;
                mode_next       = MODE_HUNT;
                prefix_run_next = '0;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        if (accept)
        begin
            res_valid_next = data_valid_next || eom_next || aborted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_char_reg  <= PREFIX_CHAR_RST;
            suffix_char_reg  <= SUFFIX_CHAR_RST;
            max_body_len_reg <= MAX_BODY_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PREFIX_CHAR:  prefix_char_reg  <= cfg_data[BYTE_W-1:0];
                CFG_SUFFIX_CHAR:  suffix_char_reg  <= cfg_data[BYTE_W-1:0];
                CFG_MAX_BODY_LEN: max_body_len_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HUNT;
            prefix_run_reg <= '0;
            suffix_run_reg <= '0;
            body_count_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            prefix_run_reg <= prefix_run_next;
            suffix_run_reg <= suffix_run_next;
            body_count_reg <= body_count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_valid_reg <= data_valid_next;
            data_byte_reg  <= data_byte_next;
            eom_reg        <= eom_next;
            aborted_reg    <= aborted_next;
            msg_length_reg <= msg_length_next;
        end
    end

    mdd_delay_line #(
        .DEPTH (MARKER_LEN)
    ) u_delay_line (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dl_ctrl),
        .din   (rx_item.rx_byte),
        .full  (dl_full),
        .head  (dl_head)
    );

    assign res.valid          = res_valid_reg;
    assign res.data_valid     = data_valid_reg;
    assign res.data_byte      = data_byte_reg;
    assign res.end_of_message = eom_reg;
    assign res.aborted        = aborted_reg;
    assign res.msg_length     = msg_length_reg;

endmodule
